// ----- src/cubical_coface_enumerator_4d_top_assert.svh -----
// Assertion macros used by the checker file.
`ifndef CUBICAL_COFACE_ENUMERATOR_4D_TOP_ASSERT_SVH
`define CUBICAL_COFACE_ENUMERATOR_4D_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CCE_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CCE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- src/cce4_pkg.sv -----
// ----------------------------------------------------------------------------
// cce4_pkg
// Types, constants and extent tables for the 4-D coface enumerator.
// ----------------------------------------------------------------------------
package cce4_pkg;

  localparam int GridSideDef  = 16;
  localparam int ValueBitsDef = 32;
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [3:0]  pos_x;
    logic [3:0]  pos_y;
    logic [3:0]  pos_z;
    logic [3:0]  pos_w;
    logic signed [31:0] voxel_value;
    logic [1:0]  cell_dim;
    logic [2:0]  cell_type;
    logic signed [31:0] cell_birthday;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  coface_x;
    logic [3:0]  coface_y;
    logic [3:0]  coface_z;
    logic [3:0]  coface_w;
    logic [2:0]  coface_type;
    logic [2:0]  coface_dim;
    logic signed [31:0] coface_birthday;
    logic        last;
  } out_item_t;

  // Number of valid types per dimension.
  function automatic logic [2:0] ext_count(input logic [2:0] dim);
    logic [2:0] r;
    begin
      case (dim)
        3'd0: r = 3'd1;
        3'd1: r = 3'd4;
        3'd2: r = 3'd6;
        3'd3: r = 3'd4;
        3'd4: r = 3'd1;
        default: r = 3'd0;
      endcase
      return r;
    end
  endfunction

  // Axis mask spanned by a cell of the given dimension and type.
  function automatic logic [3:0] ext_mask(input logic [1:0] dim, input logic [2:0] typ);
    logic [3:0] r;
    begin
      r = 4'h0;
      case (dim)
        2'd1: begin
          case (typ)
            3'd0: r = 4'h1;
            3'd1: r = 4'h2;
            3'd2: r = 4'h4;
            3'd3: r = 4'h8;
            default: r = 4'h0;
          endcase
        end
        2'd2: begin
          case (typ)
            3'd0: r = 4'h3;
            3'd1: r = 4'h5;
            3'd2: r = 4'h6;
            3'd3: r = 4'h9;
            3'd4: r = 4'hA;
            3'd5: r = 4'hC;
            default: r = 4'h0;
          endcase
        end
        2'd3: begin
          case (typ)
            3'd0: r = 4'h7;
            3'd1: r = 4'hB;
            3'd2: r = 4'hD;
            3'd3: r = 4'hE;
            default: r = 4'h0;
          endcase
        end
        default: r = 4'h0;
      endcase
      return r;
    end
  endfunction

  // Type of a coface extent, one dimension up.
  function automatic logic [2:0] type_of(input logic [3:0] m);
    logic [2:0] r;
    begin
      case (m)
        4'h1, 4'h3, 4'h7, 4'hF: r = 3'd0;
        4'h2, 4'h5, 4'hB: r = 3'd1;
        4'h4, 4'h6, 4'hD: r = 3'd2;
        4'h8, 4'h9, 4'hE: r = 3'd3;
        4'hA: r = 3'd4;
        4'hC: r = 3'd5;
        default: r = 3'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- src/cce4_grid_mem.sv -----
// ----------------------------------------------------------------------------
// cce4_grid_mem
// Voxel memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module cce4_grid_mem import cce4_pkg::*; #(
  parameter int GRID_SIDE  = GridSideDef,
  parameter int VALUE_BITS = ValueBitsDef,
  localparam int AW = 4 * $clog2(GRID_SIDE)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [VALUE_BITS-1:0] wr_data,
  input  logic [AW-1:0]         rd_addr,
  output logic [VALUE_BITS-1:0] rd_data
);
  localparam int Depth = 1 << AW;
  logic [VALUE_BITS-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ----- src/cce4_scan.sv -----
// ----------------------------------------------------------------------------
// cce4_scan
// Query sequencer: walks cofaces and their spanned voxels, one read a cycle while reading a direction.
// ----------------------------------------------------------------------------
module cce4_scan import cce4_pkg::*; #(
  parameter int GRID_SIDE  = GridSideDef,
  parameter int VALUE_BITS = ValueBitsDef,
  localparam int CW = $clog2(GRID_SIDE),
  localparam int AW = 4 * CW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  in_item_t              item,
  input  logic signed [31:0]    thr,
  output logic                  busy,
  output logic [AW-1:0]         rd_addr,
  input  logic [VALUE_BITS-1:0] rd_data,
  output logic                  out_valid,
  output out_item_t             out_item
);
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  in_item_t           q_r;
  logic [3:0]         ext_r;
  logic [2:0]         dir_r, dir_nxt;       // axis*2 + plus
  logic [3:0]         sub_r, sub_nxt;       // subset of extent
  logic               rd_v_r, rd_oob_r;     // read in flight, read outside grid
  logic signed [31:0] max_r, max_nxt;
  logic               pend_r, pend_nxt;     // a found coface waits for its successor
  out_item_t          pend_item_r, pend_item_nxt;
  logic               ov_r, ov_nxt;
  out_item_t          oi_r, oi_nxt;

  logic [1:0]         axis;
  logic               minus;
  logic               oob, skip, issue, dir_done, valid_pair, emit;
  logic [3:0]         sub_inc;
  logic signed [31:0] rv, cand;
  logic [3:0]         base [4];
  logic [7:0]         coord [4];
  logic [3:0]         corner [4];
  logic [AW-1:0]      addr;
  out_item_t          cof, fin_item;

  assign axis  = dir_r[2:1];
  assign minus = ~dir_r[0];
  assign busy  = (state_r != ST_IDLE);
  assign valid_pair = (item.cell_type < ext_count({1'b0, item.cell_dim}));

  always_comb begin
    base[0] = q_r.pos_x;
    base[1] = q_r.pos_y;
    base[2] = q_r.pos_z;
    base[3] = q_r.pos_w;
  end

  // Voxel address of the current read and the coface corner.
  always_comb begin
    oob  = 1'b0;
    addr = '0;
    for (int k = 0; k < 4; k++) begin
      coord[k] = {4'd0, base[k]} + {7'd0, sub_r[k]};
      if (axis == 2'(k)) begin
        coord[k] = minus ? coord[k] - 8'd1 : coord[k] + 8'd1;
      end
      if (coord[k] >= 8'(GRID_SIDE)) begin
        oob = 1'b1;
      end
      addr[k*CW +: CW] = coord[k][CW-1:0];
      corner[k] = base[k];
      if (axis == 2'(k) && minus) begin
        corner[k] = base[k] - 4'd1;
      end
    end
  end

  // Next subset of the extent after sub_r (masked increment).
  assign sub_inc  = ((sub_r | ~ext_r) + 4'd1) & ext_r;
  assign skip     = ext_r[axis];
  assign issue    = (state_r == ST_READ) && !skip;
  assign dir_done = (sub_inc == 4'd0);

  assign rv   = rd_oob_r ? thr : 32'(signed'(rd_data));
  assign cand = (rd_v_r && (rv > max_r)) ? rv : max_r;
  assign emit = (state_r == ST_EVAL) && (cand != thr);

  always_comb begin
    cof                 = '0;
    cof.found           = 1'b1;
    cof.coface_x        = corner[0];
    cof.coface_y        = corner[1];
    cof.coface_z        = corner[2];
    cof.coface_w        = corner[3];
    cof.coface_type     = type_of(ext_r | (4'd1 << axis));
    cof.coface_dim      = {1'b0, q_r.cell_dim} + 3'd1;
    cof.coface_birthday = cand;
    cof.last            = 1'b0;
  end

  // Final result of a query: the held coface, or a not-found result.
  always_comb begin
    fin_item = '0;
    if (pend_r) begin
      fin_item = pend_item_r;
    end
    fin_item.last = 1'b1;
  end

  assign rd_addr = addr;

  always_comb begin
    state_nxt = state_r;
    dir_nxt   = dir_r;
    sub_nxt   = sub_r;
    max_nxt   = max_r;
    case (state_r)
      ST_IDLE: begin
        if (start && item.kind == KIND_QUERY) begin
          dir_nxt   = 3'd7;
          sub_nxt   = 4'd0;
          max_nxt   = item.cell_birthday;
          state_nxt = valid_pair ? ST_READ : ST_FIN;
        end
      end
      ST_READ: begin
        if (skip) begin
          if (dir_r == 3'd0) begin
            state_nxt = ST_FIN;
          end else begin
            dir_nxt = dir_r - 3'd1;
          end
        end else begin
          max_nxt = cand;
          if (dir_done) begin
            state_nxt = ST_EVAL;
          end else begin
            sub_nxt = sub_inc;
          end
        end
      end
      ST_EVAL: begin
        // The last read of this direction returns now.
        max_nxt = q_r.cell_birthday;
        sub_nxt = 4'd0;
        if (dir_r == 3'd0) begin
          state_nxt = ST_FIN;
        end else begin
          dir_nxt   = dir_r - 3'd1;
          state_nxt = ST_READ;
        end
      end
      ST_FIN: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pend_nxt      = pend_r;
    pend_item_nxt = pend_item_r;
    ov_nxt        = 1'b0;
    oi_nxt        = oi_r;
    if (state_r == ST_FIN) begin
      ov_nxt   = 1'b1;
      oi_nxt   = fin_item;
      pend_nxt = 1'b0;
    end else if (emit) begin
      pend_nxt      = 1'b1;
      pend_item_nxt = cof;
      if (pend_r) begin
        ov_nxt = 1'b1;
        oi_nxt = pend_item_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      q_r         <= '0;
      ext_r       <= 4'd0;
      dir_r       <= 3'd0;
      sub_r       <= 4'd0;
      max_r       <= '0;
      rd_v_r      <= 1'b0;
      rd_oob_r    <= 1'b0;
      pend_r      <= 1'b0;
      pend_item_r <= '0;
      ov_r        <= 1'b0;
      oi_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      dir_r       <= dir_nxt;
      sub_r       <= sub_nxt;
      max_r       <= max_nxt;
      rd_v_r      <= issue;
      rd_oob_r    <= oob;
      pend_r      <= pend_nxt;
      pend_item_r <= pend_item_nxt;
      ov_r        <= ov_nxt;
      oi_r        <= oi_nxt;
      if (state_r == ST_IDLE && start) begin
        q_r   <= item;
        ext_r <= ext_mask(item.cell_dim, item.cell_type);
      end
    end
  end

  assign out_valid = ov_r;
  assign out_item  = oi_r;
endmodule

// ----- src/cubical_coface_enumerator_4d_top.sv -----
// ----------------------------------------------------------------------------
// cubical_coface_enumerator_4d_top
// 4-D voxel grid with a coface enumerator for cubical cells.
// ----------------------------------------------------------------------------
// Usage: drive in_item with start high; the transaction is taken at the rising
// edge where busy is low. A load transaction (kind 0) writes one voxel at that
// edge, gives no result and never raises busy, so loads run back to back.
// A query transaction (kind 1) raises busy from the next cycle and walks the
// cofaces from the w axis down to x, plus before minus. An axis the cell
// spans is skipped in both directions; every other axis gives two cofaces,
// each reading its spanned voxels (1, 2, 4 or 8 reads) and then evaluating
// the last read. On an invalid dimension and type pair the query goes
// straight to its closing step. The grid memory has a single read port,
// one voxel per cycle. Each result shows for one cycle with out_valid high;
// the final one carries last and appears in the same cycle that busy falls.
// A query with no coface gives one not-found result. The receiver cannot
// stall: results must be taken as they appear. cfg_we writes the threshold;
// the user must use it only while the block is idle, as the block itself
// does not enforce this. Reset clears the sequencer and sets the threshold
// to the largest value; the grid memory is not cleared.
// ----------------------------------------------------------------------------
module cubical_coface_enumerator_4d_top import cce4_pkg::*; #(
  parameter int GRID_SIDE  = GridSideDef,
  parameter int VALUE_BITS = ValueBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  localparam int CW = $clog2(GRID_SIDE);
  localparam int AW = 4 * CW;

  logic signed [31:0] thr_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [VALUE_BITS-1:0] rd_data;
  logic wr_en, in_grid;
  logic [7:0] wx, wy, wz, ww;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 32'sh7fffffff;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // Loads outside a grid smaller than 16 are dropped.
  assign wx = {4'd0, in_item.pos_x};
  assign wy = {4'd0, in_item.pos_y};
  assign wz = {4'd0, in_item.pos_z};
  assign ww = {4'd0, in_item.pos_w};
  assign in_grid = (wx < 8'(GRID_SIDE)) && (wy < 8'(GRID_SIDE)) &&
                   (wz < 8'(GRID_SIDE)) && (ww < 8'(GRID_SIDE));
  assign wr_en = start && !busy && (in_item.kind == KIND_LOAD) && in_grid;
  assign wr_addr = {ww[CW-1:0], wz[CW-1:0], wy[CW-1:0], wx[CW-1:0]};

  cce4_grid_mem #(.GRID_SIDE(GRID_SIDE), .VALUE_BITS(VALUE_BITS)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr),
    .wr_data(VALUE_BITS'(in_item.voxel_value)),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  cce4_scan #(.GRID_SIDE(GRID_SIDE), .VALUE_BITS(VALUE_BITS)) u_scan (
    .clk(clk), .rst_n(rst_n), .start(start), .item(in_item), .thr(thr_r),
    .busy(busy), .rd_addr(rd_addr), .rd_data(rd_data),
    .out_valid(out_valid), .out_item(out_item)
  );
endmodule

// ----- src/cce4_checker.sv -----
// ----------------------------------------------------------------------------
// cce4_checker
// Port-level checks for the coface enumerator.
// ----------------------------------------------------------------------------
`include "cubical_coface_enumerator_4d_top_assert.svh"
module cce4_checker import cce4_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);
  `CCE_ASSERT_IMP(a_nf_last, clk, rst_n, out_valid && !out_item.found, out_item.last,
    "not-found result without last")
  `CCE_ASSERT_IMP(a_dim, clk, rst_n, out_valid && out_item.found,
    out_item.coface_dim != 3'd0, "coface dimension zero")
  `CCE_ASSERT_NEXT(a_load_idle, clk, rst_n, start && !busy && in_item.kind == KIND_LOAD,
    !busy, "load made the block busy")
  `CCE_ASSERT_NEXT(a_query_busy, clk, rst_n, start && !busy && in_item.kind == KIND_QUERY,
    busy, "query did not start")
endmodule

bind cubical_coface_enumerator_4d_top cce4_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
  .out_valid(out_valid), .out_item(out_item)
);
